FILE: rtl/scmd_pkg.sv
// Shared types and constants for the shell command tokenizer.
`default_nettype none
package scmd_pkg;

	localparam int MAX_LINE_DEF = 4096;
	localparam int CHAR_W       = 8;
	localparam int START_W      = 12;
	localparam int LEN_W        = 13;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LESS  = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_GREAT = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;

	typedef enum logic [3:0] {
		TK_WORD     = 4'd0,
		TK_LESS     = 4'd1,
		TK_GREAT    = 4'd2,
		TK_DGREAT   = 4'd3,
		TK_PIPE     = 4'd4,
		TK_OR_IF    = 4'd5,
		TK_AND_IF   = 4'd6,
		TK_SEMI     = 4'd7,
		TK_END      = 4'd8,
		TK_SYNTAX   = 4'd9,
		TK_TOO_LONG = 4'd10
	} token_kind_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_GREAT = 2'd1,
		PEND_PIPE  = 2'd2,
		PEND_AMP   = 2'd3
	} pend_t;

	typedef struct packed {
		token_kind_t         kind;
		logic [START_W-1:0]  start;
		logic [LEN_W-1:0]    length;
		logic                last;
	} tok_t;

	// up to two tokens produced by one byte
	typedef struct packed {
		logic [1:0] n;
		tok_t       r1;
		tok_t       r0;
	} tok_push_t;

	function automatic tok_t mk_tok(token_kind_t kind, logic [START_W-1:0] start,
			logic [LEN_W-1:0] length);
		tok_t t;
		t.kind   = kind;
		t.start  = start;
		t.length = length;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/scmd_lexer.sv
// Lexer state and per-byte token decode.
`default_nettype none
module scmd_lexer #(
	parameter int MaxLine = scmd_pkg::MAX_LINE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [scmd_pkg::CHAR_W-1:0]   c,
	output scmd_pkg::tok_push_t                push
);

	localparam int POS_W = $clog2(MaxLine + 1);
	localparam int EXT_W = (POS_W > scmd_pkg::LEN_W) ? POS_W : scmd_pkg::LEN_W;

	scmd_pkg::pend_t   pend_q, pend_n;
	logic              in_word_q, in_word_n;
	logic [POS_W-1:0]  begin_q, begin_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic              disc_q, disc_n;

	function automatic logic ends_word(logic [scmd_pkg::CHAR_W-1:0] b);
		return b == scmd_pkg::CH_NUL || b == scmd_pkg::CH_SPACE || b == scmd_pkg::CH_TAB ||
			b == scmd_pkg::CH_LESS || b == scmd_pkg::CH_GREAT || b == scmd_pkg::CH_PIPE ||
			b == scmd_pkg::CH_SEMI || b == scmd_pkg::CH_AMP;
	endfunction

	always_comb begin
		scmd_pkg::tok_t  res [2];
		logic [1:0]      n;
		logic            do_plain;
		logic            skip_tail;
		logic            plain_sw;
		logic [EXT_W-1:0] ext_start;
		logic [EXT_W-1:0] ext_len;
		scmd_pkg::tok_t  t;

		res[0]    = scmd_pkg::mk_tok(scmd_pkg::TK_WORD, '0, '0);
		res[1]    = scmd_pkg::mk_tok(scmd_pkg::TK_WORD, '0, '0);
		n         = 2'd0;
		do_plain  = 1'b0;
		skip_tail = 1'b0;
		plain_sw  = 1'b0;
		ext_start = EXT_W'(begin_q);
		ext_len   = EXT_W'(pos_q) - EXT_W'(begin_q);
		t         = scmd_pkg::mk_tok(scmd_pkg::TK_WORD, '0, '0);
		pend_n    = pend_q;
		in_word_n = in_word_q;
		begin_n   = begin_q;
		pos_n     = pos_q;
		disc_n    = disc_q;

		if (disc_q) begin
			if (c == scmd_pkg::CH_NUL) begin
				pend_n    = scmd_pkg::PEND_NONE;
				in_word_n = 1'b0;
				begin_n   = '0;
				pos_n     = '0;
				disc_n    = 1'b0;
			end
		end else if (c != scmd_pkg::CH_NUL && pos_q >= POS_W'(MaxLine)) begin
			res[0]    = scmd_pkg::mk_tok(scmd_pkg::TK_TOO_LONG, '0, '0);
			n         = 2'd1;
			pend_n    = scmd_pkg::PEND_NONE;
			in_word_n = 1'b0;
			begin_n   = '0;
			disc_n    = 1'b1;
		end else begin
			pend_n = scmd_pkg::PEND_NONE;
			unique case (pend_q)
				scmd_pkg::PEND_GREAT: begin
					if (c == scmd_pkg::CH_GREAT) begin
						res[0] = scmd_pkg::mk_tok(scmd_pkg::TK_DGREAT, '0, '0);
					end else begin
						res[0]   = scmd_pkg::mk_tok(scmd_pkg::TK_GREAT, '0, '0);
						do_plain = 1'b1;
					end
					n = 2'd1;
				end
				scmd_pkg::PEND_PIPE: begin
					if (c == scmd_pkg::CH_PIPE) begin
						res[0] = scmd_pkg::mk_tok(scmd_pkg::TK_OR_IF, '0, '0);
					end else begin
						res[0]   = scmd_pkg::mk_tok(scmd_pkg::TK_PIPE, '0, '0);
						do_plain = 1'b1;
					end
					n = 2'd1;
				end
				scmd_pkg::PEND_AMP: begin
					n = 2'd1;
					if (c == scmd_pkg::CH_AMP) begin
						res[0] = scmd_pkg::mk_tok(scmd_pkg::TK_AND_IF, '0, '0);
					end else begin
						res[0]    = scmd_pkg::mk_tok(scmd_pkg::TK_SYNTAX, '0, '0);
						in_word_n = 1'b0;
						skip_tail = 1'b1;
						if (c == scmd_pkg::CH_NUL) begin
							begin_n = '0;
							pos_n   = '0;
						end else begin
							disc_n = 1'b1;
						end
					end
				end
				default: begin
					do_plain = 1'b1;
				end
			endcase

			if (do_plain) begin
				plain_sw = 1'b1;
				if (in_word_q) begin
					if (ends_word(c)) begin
						res[n[0]] = scmd_pkg::mk_tok(scmd_pkg::TK_WORD,
							ext_start[scmd_pkg::START_W-1:0], ext_len[scmd_pkg::LEN_W-1:0]);
						n         = n + 2'd1;
						in_word_n = 1'b0;
					end else begin
						plain_sw = 1'b0;
					end
				end
				if (plain_sw) begin
					t = scmd_pkg::mk_tok(scmd_pkg::TK_WORD, '0, '0);
					case (c)
						scmd_pkg::CH_NUL: begin
							t         = scmd_pkg::mk_tok(scmd_pkg::TK_END, '0, '0);
							res[n[0]] = t;
							n         = n + 2'd1;
						end
						scmd_pkg::CH_SPACE, scmd_pkg::CH_TAB: begin
						end
						scmd_pkg::CH_LESS: begin
							t         = scmd_pkg::mk_tok(scmd_pkg::TK_LESS, '0, '0);
							res[n[0]] = t;
							n         = n + 2'd1;
						end
						scmd_pkg::CH_SEMI: begin
							t         = scmd_pkg::mk_tok(scmd_pkg::TK_SEMI, '0, '0);
							res[n[0]] = t;
							n         = n + 2'd1;
						end
						scmd_pkg::CH_GREAT: pend_n = scmd_pkg::PEND_GREAT;
						scmd_pkg::CH_PIPE:  pend_n = scmd_pkg::PEND_PIPE;
						scmd_pkg::CH_AMP:   pend_n = scmd_pkg::PEND_AMP;
						default: begin
							in_word_n = 1'b1;
							begin_n   = pos_q;
						end
					endcase
				end
			end

			if (!skip_tail) begin
				if (c == scmd_pkg::CH_NUL) begin
					pend_n    = scmd_pkg::PEND_NONE;
					in_word_n = 1'b0;
					begin_n   = '0;
					pos_n     = '0;
					disc_n    = 1'b0;
				end else begin
					pos_n = pos_q + POS_W'(1);
				end
			end
		end

		if (n == 2'd1) begin
			res[0].last = 1'b1;
		end else if (n == 2'd2) begin
			res[1].last = 1'b1;
		end
		push.n  = en ? n : 2'd0;
		push.r0 = res[0];
		push.r1 = res[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= scmd_pkg::PEND_NONE;
			in_word_q <= 1'b0;
			begin_q   <= '0;
			pos_q     <= '0;
			disc_q    <= 1'b0;
		end else if (en) begin
			pend_q    <= pend_n;
			in_word_q <= in_word_n;
			begin_q   <= begin_n;
			pos_q     <= pos_n;
			disc_q    <= disc_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/scmd_outq.sv
// Four-entry token queue, two writes and one read per cycle.
`default_nettype none
module scmd_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scmd_pkg::tok_push_t push,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output scmd_pkg::tok_t           out_tok
);

	localparam int PTR_W = $clog2(scmd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	scmd_pkg::tok_t     ent_q [scmd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;
	logic [PTR_W-1:0]   wr_1;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_tok   = ent_q[rd_q];
	assign room      = cnt_q <= CNT_W'(scmd_pkg::QUEUE_DEPTH - 2);
	assign wr_1      = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/shell_command_tokenizer.sv
// Top level of the shell command tokenizer.
//
// Bytes of a command line enter on the s_ stream, one per request, in
// s_tdata[7:0]; a zero byte ends the line. Tokens leave on the m_ stream:
// m_tuser holds the token kind, m_tdata the word start and length, and
// m_tlast marks the last token caused by one input byte.
// A byte is taken into an input register, decoded against the lexer state
// once the output queue has room, and its zero, one or two tokens are written into a
// four-entry output queue. Each token passes the input register and then the
// queue entry registers before it is offered on the m_ stream.
// Throughput is one byte per cycle while each byte gives at most one token
// and the receiver does not stall; a byte that gives two tokens is read out
// one token at a time through the single read port of the output queue.
// When the receiver stalls the queue fills; the decode stage waits until
// two queue entries are free, and s_tready falls once the input register
// is also held. No token is lost or repeated.
// Reset clears the lexer to the start of a line and empties the queue.
`default_nettype none
module shell_command_tokenizer #(
	parameter int MAX_LINE = scmd_pkg::MAX_LINE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [11:0] word_start, [24:12] word_length, rest zero
	output logic [3:0]       m_tuser,   // [3:0] token_kind
	output logic             m_tlast    // last
);

	logic                          valid_s1;
	logic [scmd_pkg::CHAR_W-1:0]   byte_s1;
	logic                          room;
	logic                          advance;
	scmd_pkg::tok_push_t           push;
	scmd_pkg::tok_t                head;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	scmd_lexer #(
		.MaxLine(MAX_LINE)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.c      (byte_s1),
		.push   (push)
	);

	scmd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (head)
	);

	assign m_tuser = head.kind;
	assign m_tdata = {7'd0, head.length, head.start};
	assign m_tlast = head.last;

endmodule
`default_nettype wire

FILE: dv/tb_shell_command_tokenizer.sv
// Testbench for shell_command_tokenizer: directed and random lines against a token predictor.
`default_nettype none
module tb_shell_command_tokenizer;

	localparam int LINE_MAX     = scmd_pkg::MAX_LINE_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BYTES = 1200;
	localparam int MAX_REPORTS  = 100;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	shell_command_tokenizer #(
		.MAX_LINE(LINE_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// lexer state mirrored by the predictor
	scmd_pkg::pend_t held_op   = scmd_pkg::PEND_NONE;
	bit              word_open = 1'b0;
	logic [11:0]     word_from = '0;
	logic [12:0]     line_pos  = '0;
	bit              dropping  = 1'b0;

	scmd_pkg::tok_t  tokens_due[$];
	scmd_pkg::tok_t  step_tokens[$];

	int          mismatches     = 0;
	int          cycles         = 0;
	int          bytes_sent     = 0;
	int          tx_gap_max     = 0;
	int          rx_stall_max   = 0;
	int          rx_hold_cycles = 0;

	string       op_text[7] = '{"<", ">", ">>", "|", "||", "&&", ";"};

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void emit_token(scmd_pkg::token_kind_t kind, logic [11:0] start,
			logic [12:0] length);
		step_tokens.push_back(scmd_pkg::tok_t'{kind: kind, start: start, length: length,
			last: 1'b0});
	endfunction

	function automatic void clear_line();
		held_op   = scmd_pkg::PEND_NONE;
		word_open = 1'b0;
		word_from = '0;
		line_pos  = '0;
		dropping  = 1'b0;
	endfunction

	function automatic void lex_plain(logic [7:0] c);
		if (word_open) begin
			if (!(c inside {scmd_pkg::CH_NUL, scmd_pkg::CH_SPACE, scmd_pkg::CH_TAB,
					scmd_pkg::CH_LESS, scmd_pkg::CH_GREAT, scmd_pkg::CH_PIPE,
					scmd_pkg::CH_SEMI, scmd_pkg::CH_AMP}))
				return;
			emit_token(scmd_pkg::TK_WORD, word_from, line_pos - 13'(word_from));
			word_open = 1'b0;
		end
		case (c)
			scmd_pkg::CH_NUL:   emit_token(scmd_pkg::TK_END, '0, '0);
			scmd_pkg::CH_SPACE, scmd_pkg::CH_TAB: ;
			scmd_pkg::CH_LESS:  emit_token(scmd_pkg::TK_LESS, '0, '0);
			scmd_pkg::CH_SEMI:  emit_token(scmd_pkg::TK_SEMI, '0, '0);
			scmd_pkg::CH_GREAT: held_op = scmd_pkg::PEND_GREAT;
			scmd_pkg::CH_PIPE:  held_op = scmd_pkg::PEND_PIPE;
			scmd_pkg::CH_AMP:   held_op = scmd_pkg::PEND_AMP;
			default: begin
				word_open = 1'b1;
				word_from = line_pos[11:0];
			end
		endcase
	endfunction

	// works out the tokens caused by one accepted byte and queues them
	function automatic void lex_byte(logic [7:0] c);
		scmd_pkg::pend_t op;
		bit              line_done;
		line_done = 1'b0;
		step_tokens.delete();
		if (dropping) begin
			if (c == scmd_pkg::CH_NUL)
				clear_line();
		end else if (c != scmd_pkg::CH_NUL && line_pos >= LINE_MAX) begin
			emit_token(scmd_pkg::TK_TOO_LONG, '0, '0);
			held_op   = scmd_pkg::PEND_NONE;
			word_open = 1'b0;
			word_from = '0;
			dropping  = 1'b1;
		end else begin
			op      = held_op;
			held_op = scmd_pkg::PEND_NONE;
			case (op)
				scmd_pkg::PEND_GREAT: begin
					if (c == scmd_pkg::CH_GREAT)
						emit_token(scmd_pkg::TK_DGREAT, '0, '0);
					else begin
						emit_token(scmd_pkg::TK_GREAT, '0, '0);
						lex_plain(c);
					end
				end
				scmd_pkg::PEND_PIPE: begin
					if (c == scmd_pkg::CH_PIPE)
						emit_token(scmd_pkg::TK_OR_IF, '0, '0);
					else begin
						emit_token(scmd_pkg::TK_PIPE, '0, '0);
						lex_plain(c);
					end
				end
				scmd_pkg::PEND_AMP: begin
					if (c == scmd_pkg::CH_AMP)
						emit_token(scmd_pkg::TK_AND_IF, '0, '0);
					else begin
						emit_token(scmd_pkg::TK_SYNTAX, '0, '0);
						word_open = 1'b0;
						line_done = 1'b1;
						if (c == scmd_pkg::CH_NUL)
							clear_line();
						else
							dropping = 1'b1;
					end
				end
				default: lex_plain(c);
			endcase
			if (!line_done) begin
				if (c == scmd_pkg::CH_NUL)
					clear_line();
				else
					line_pos = line_pos + 13'd1;
			end
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
	endfunction

	function automatic void note_mismatch(string field, int want, int got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	always @(posedge clk) begin
		scmd_pkg::tok_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (tokens_due.size() == 0)
				note_mismatch("token with none due, token_kind", -1, m_tuser);
			else begin
				want = tokens_due.pop_front();
				if (m_tuser !== want.kind)
					note_mismatch("token_kind", want.kind, m_tuser);
				if (m_tdata[11:0] !== want.start)
					note_mismatch("word_start", want.start, m_tdata[11:0]);
				if (m_tdata[24:12] !== want.length)
					note_mismatch("word_length", want.length, m_tdata[24:12]);
				if (m_tlast !== want.last)
					note_mismatch("last", want.last, m_tlast);
				if (m_tdata[31:25] !== '0)
					note_mismatch("tdata padding", 0, m_tdata[31:25]);
			end
		end
	end

	// token receiver; a hold request stalls it for a counted stretch
	initial begin : receiver
		int wait_cycles;
		wait (arst_n === 1'b1);
		forever begin
			wait_cycles    = rx_hold_cycles + $urandom_range(0, rx_stall_max);
			rx_hold_cycles = 0;
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
		end
	end

	// one request per byte; valid stays high when no gap follows
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		lex_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b inside {scmd_pkg::CH_SPACE, scmd_pkg::CH_TAB, scmd_pkg::CH_LESS,
			scmd_pkg::CH_GREAT, scmd_pkg::CH_PIPE, scmd_pkg::CH_SEMI, scmd_pkg::CH_AMP});
		return b;
	endfunction

	task automatic set_idling(input int tx, input int rx);
		tx_gap_max   = tx;
		rx_stall_max = rx;
	endtask

	task automatic test_plain_lines();
		set_idling(12, 12);
		send_byte(scmd_pkg::CH_NUL);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(scmd_pkg::CH_SPACE);
		send_byte(8'h01);
		send_byte(scmd_pkg::CH_TAB);
		send_byte(8'h7F);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(scmd_pkg::CH_NUL);
	endtask

	task automatic test_operators();
		set_idling(0, 0);
		send_text("a<b>c>>d|e||f&&g;h");
		send_byte(scmd_pkg::CH_NUL);
		set_idling(12, 0);
		send_text("x >");
		send_byte(scmd_pkg::CH_NUL);
		send_text("|");
		send_byte(scmd_pkg::CH_NUL);
		send_text("&&");
		send_byte(scmd_pkg::CH_NUL);
	endtask

	task automatic test_lone_ampersand();
		set_idling(3, 12);
		send_text("a & b>|");
		send_byte(scmd_pkg::CH_NUL);
		send_text("&");
		send_byte(scmd_pkg::CH_NUL);
		send_text("x&;y");
		send_byte(scmd_pkg::CH_NUL);
		send_text("z");
		send_byte(scmd_pkg::CH_NUL);
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		rx_hold_cycles = 300;
		repeat (30) send_text("v<");
		send_byte(scmd_pkg::CH_NUL);
		repeat (20) send_text(">;");
		send_byte(scmd_pkg::CH_NUL);
	endtask

	task automatic test_line_length();
		set_idling(2, 2);
		// long word, operator at the last offset, then overflow and dropped bytes
		for (int i = 0; i < LINE_MAX - 1; i++)
			send_byte(word_byte());
		send_text(">x&&|");
		send_byte(scmd_pkg::CH_NUL);
		send_text("ok");
		send_byte(scmd_pkg::CH_NUL);
	endtask

	task automatic test_random();
		int first;
		int pick;
		int n;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			set_idling($urandom_range(0, 3) == 0 ? 0 : 12, $urandom_range(0, 3) == 0 ? 0 : 12);
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				n = $urandom_range(0, 8);
				repeat (n) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: repeat ($urandom_range(1, 6)) send_byte(word_byte());
						5, 6, 7:       send_text(op_text[$urandom_range(0, 6)]);
						default:       repeat ($urandom_range(1, 3))
							send_byte($urandom_range(0, 1) ? scmd_pkg::CH_SPACE :
								scmd_pkg::CH_TAB);
					endcase
					if ($urandom_range(0, 1))
						send_byte(scmd_pkg::CH_SPACE);
				end
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(0, 2)) send_byte(word_byte());
				send_byte(scmd_pkg::CH_AMP);
				repeat ($urandom_range(0, 3)) begin
					case ($urandom_range(0, 3))
						0:       send_byte(word_byte());
						1:       send_byte(scmd_pkg::CH_AMP);
						2:       send_text(op_text[$urandom_range(0, 6)]);
						default: send_byte(scmd_pkg::CH_SPACE);
					endcase
				end
			end
			send_byte(scmd_pkg::CH_NUL);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_lines();
		test_operators();
		test_lone_ampersand();
		test_backpressure();
		test_line_length();
		test_random();
		s_tvalid <= 1'b0;
		while (tokens_due.size() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

FILE: shell_command_tokenizer.f
rtl/scmd_pkg.sv
rtl/scmd_lexer.sv
rtl/scmd_outq.sv
rtl/shell_command_tokenizer.sv
dv/tb_shell_command_tokenizer.sv
